// File: rtl/ptdec_pkg.sv
// ptdec_pkg: shared widths, codes and word types for the point/trace decimator.
// No dependencies; compiled first.
package ptdec_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int COUNT_WIDTH = 16;
    localparam int INDEX_WIDTH = 16;
    localparam int CMD_WIDTH   = 3;
    localparam int KIND_WIDTH  = 3;
    localparam int PLANE_WIDTH = 2;
    localparam int DIST_WIDTH  = 16;
    localparam int MIN_SQ_W    = 2 * DIST_WIDTH;
    localparam int SUM_W       = 2 * COORD_WIDTH + 4;
    localparam int CMP_W       = (SUM_W > MIN_SQ_W) ? SUM_W : MIN_SQ_W;

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_MIN_DIST = APB_AW'(0);
    localparam logic [DIST_WIDTH-1:0] MIN_DIST_RST = DIST_WIDTH'(100);

    localparam int NRES       = 3;
    localparam int NCNT_W     = $clog2(NRES + 1);
    localparam int OBUF_DEPTH = 4;
    localparam int PTR_W      = $clog2(OBUF_DEPTH);

    localparam logic [CMD_WIDTH-1:0] CMD_NONE     = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_PLANE_XY = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_PLANE_XZ = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_PLANE_YZ = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_RST_CNT  = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_SAMPLE   = 3'd5;
    localparam logic [CMD_WIDTH-1:0] CMD_TRACE    = 3'd6;

    localparam logic [PLANE_WIDTH-1:0] PLANE_XY = 2'd0;
    localparam logic [PLANE_WIDTH-1:0] PLANE_XZ = 2'd1;
    localparam logic [PLANE_WIDTH-1:0] PLANE_YZ = 2'd2;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_PLANE       = 3'd0,
        KIND_CNT_RST     = 3'd1,
        KIND_POINT       = 3'd2,
        KIND_TRACE_START = 3'd3,
        KIND_TRACE_POINT = 3'd4,
        KIND_TRACE_STOP  = 3'd5
    } kind_t;

    typedef struct packed {
        logic [CMD_WIDTH-1:0]    cmd;
        logic                    sample_button;
        logic signed [COORD_WIDTH-1:0] tip_x;
        logic signed [COORD_WIDTH-1:0] tip_y;
        logic signed [COORD_WIDTH-1:0] tip_z;
    } in_t;

    typedef struct packed {
        kind_t                   kind;
        logic [INDEX_WIDTH-1:0]  index;
        logic signed [COORD_WIDTH-1:0] coord_a;
        logic signed [COORD_WIDTH-1:0] coord_b;
        logic signed [COORD_WIDTH-1:0] coord_c;
        logic [PLANE_WIDTH-1:0]  plane_now;
        logic                    tracing;
        logic                    last;
    } res_t;

    typedef struct packed {
        logic [NCNT_W-1:0]       n;
        res_t [NRES-1:0]         res;
    } res_set_t;

endpackage

// File: rtl/ptdec_in_if.sv
// ptdec_in_if: input sample channel (valid/ready plus sample word).
// Depends on ptdec_pkg.
interface ptdec_in_if;
    import ptdec_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CMD_WIDTH-1:0]          cmd;
    logic                          sample_button;
    logic signed [COORD_WIDTH-1:0] tip_x;
    logic signed [COORD_WIDTH-1:0] tip_y;
    logic signed [COORD_WIDTH-1:0] tip_z;

    modport source (output valid, cmd, sample_button, tip_x, tip_y, tip_z, input ready);
    modport sink   (input valid, cmd, sample_button, tip_x, tip_y, tip_z, output ready);
endinterface

// File: rtl/ptdec_out_if.sv
// ptdec_out_if: result channel (valid/ready plus result word).
// Depends on ptdec_pkg.
interface ptdec_out_if;
    import ptdec_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [KIND_WIDTH-1:0]         kind;
    logic [INDEX_WIDTH-1:0]        index;
    logic signed [COORD_WIDTH-1:0] coord_a;
    logic signed [COORD_WIDTH-1:0] coord_b;
    logic signed [COORD_WIDTH-1:0] coord_c;
    logic [PLANE_WIDTH-1:0]        plane_now;
    logic                          tracing;
    logic                          last;

    modport source (output valid, kind, index, coord_a, coord_b, coord_c, plane_now,
                    tracing, last, input ready);
    modport sink   (input valid, kind, index, coord_a, coord_b, coord_c, plane_now,
                    tracing, last, output ready);
endinterface

// File: rtl/point_sample_and_trace_decimator_core.sv
// Point sample and trace decimator: a sample word is registered, evaluated
// combinationally against the mode/counter state, and its zero to three result words
// enter a four-word output FIFO that drains one word per cycle while the output is
// not stalled. A sample with at most one result can be taken every cycle while the
// output is not stalled; a sample with k results occupies the output port for k words,
// so the output port (one word per cycle) sets the sustained rate. A sample waits in
// the input register until the FIFO has room; its results are then written to the FIFO.
// Depends on ptdec_pkg, ptdec_in_if, ptdec_out_if, ptdec_cfg, ptdec_eval, ptdec_obuf.
module point_sample_and_trace_decimator_core (
    input  logic                         clk,
    input  logic                         rst_n,
    ptdec_in_if.sink                     in_ch,
    ptdec_out_if.source                  out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptdec_pkg::APB_AW-1:0] paddr,
    input  logic [ptdec_pkg::APB_DW-1:0] pwdata,
    output logic [ptdec_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import ptdec_pkg::*;

    logic                in_v_reg;
    in_t                 in_item_reg;
    logic                commit;
    logic                room;
    logic [MIN_SQ_W-1:0] min_sq;
    res_set_t            set;

    assign commit      = in_v_reg && room;
    assign in_ch.ready = !in_v_reg || commit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_v_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_item_reg.cmd           <= in_ch.cmd;
            in_item_reg.sample_button <= in_ch.sample_button;
            in_item_reg.tip_x         <= in_ch.tip_x;
            in_item_reg.tip_y         <= in_ch.tip_y;
            in_item_reg.tip_z         <= in_ch.tip_z;
        end
    end

    ptdec_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .min_sq  (min_sq)
    );

    ptdec_eval u_eval (
        .clk     (clk),
        .rst_n   (rst_n),
        .commit  (commit),
        .item    (in_item_reg),
        .min_sq  (min_sq),
        .set_out (set)
    );

    ptdec_obuf u_obuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (commit),
        .set_in (set),
        .room   (room),
        .out_ch (out_ch)
    );

`ifndef SYNTH
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_v_reg && !commit |=> in_v_reg && $stable(in_item_reg))
        else $error("pending sample lost or changed");

    a_burst_contig: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.ready && !out_ch.last |=> out_ch.valid)
        else $error("result burst broken before last word");

    a_start_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.kind == KIND_TRACE_START |-> out_ch.tracing)
        else $error("trace start word without trace mode");

    a_stop_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.kind == KIND_TRACE_STOP |-> !out_ch.tracing && out_ch.last)
        else $error("trace stop word with trace mode or not last");
`endif
endmodule

// File: rtl/ptdec_cfg.sv
// ptdec_cfg: APB register for the minimum trace distance, keeps its square.
// Depends on ptdec_pkg.
module ptdec_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ptdec_pkg::APB_AW-1:0] paddr,
    input  logic [ptdec_pkg::APB_DW-1:0] pwdata,
    output logic [ptdec_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    output logic [ptdec_pkg::MIN_SQ_W-1:0] min_sq
);
    import ptdec_pkg::*;

    logic [DIST_WIDTH-1:0] min_dist_reg;
    logic [MIN_SQ_W-1:0]   min_sq_reg;
    logic [DIST_WIDTH-1:0] wdist;
    logic                  wr_en;

    assign pready = 1'b1;
    assign wdist  = pwdata[DIST_WIDTH-1:0];
    assign wr_en  = psel && penable && pwrite && (paddr == REG_MIN_DIST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= MIN_DIST_RST;
            min_sq_reg   <= MIN_SQ_W'(MIN_DIST_RST) * MIN_SQ_W'(MIN_DIST_RST);
        end
        else if (wr_en)
        begin
            min_dist_reg <= wdist;
            min_sq_reg   <= MIN_SQ_W'(wdist) * MIN_SQ_W'(wdist);
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_MIN_DIST: prdata = APB_DW'(min_dist_reg);
            default:      prdata = '0;
        endcase
    end

    assign min_sq = min_sq_reg;
endmodule

// File: rtl/ptdec_eval.sv
// ptdec_eval: mode/counter/last-trace state and the per-sample decision logic.
// Depends on ptdec_pkg; produces up to NRES result words per committed sample.
module ptdec_eval (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           commit,
    input  ptdec_pkg::in_t                 item,
    input  logic [ptdec_pkg::MIN_SQ_W-1:0] min_sq,
    output ptdec_pkg::res_set_t            set_out
);
    import ptdec_pkg::*;

    logic                          mode_reg, mode_next;
    logic [COUNT_WIDTH-1:0]        pc_reg, pc_next;
    logic [COUNT_WIDTH-1:0]        tc_reg, tc_next;
    logic signed [COORD_WIDTH-1:0] lx_reg, lx_next;
    logic signed [COORD_WIDTH-1:0] ly_reg, ly_next;
    logic signed [COORD_WIDTH-1:0] lz_reg, lz_next;
    logic [PLANE_WIDTH-1:0]        plane_reg, plane_next;

    logic signed [COORD_WIDTH:0] dx, dy, dz;
    logic [COORD_WIDTH:0]        mx, my, mz;
    logic [2*COORD_WIDTH+1:0]    sx, sy, sz;
    logic [CMP_W-1:0]            sum;
    logic                        far;

    function automatic res_t mk_res(kind_t k, logic [COUNT_WIDTH-1:0] idx,
                                    logic signed [COORD_WIDTH-1:0] a,
                                    logic signed [COORD_WIDTH-1:0] b,
                                    logic signed [COORD_WIDTH-1:0] c);
        res_t r;
        r         = '0;
        r.kind    = k;
        r.index   = INDEX_WIDTH'(idx);
        r.coord_a = a;
        r.coord_b = b;
        r.coord_c = c;
        return r;
    endfunction

    always_comb
    begin
        dx  = {item.tip_x[COORD_WIDTH-1], item.tip_x} - {lx_reg[COORD_WIDTH-1], lx_reg};
        dy  = {item.tip_y[COORD_WIDTH-1], item.tip_y} - {ly_reg[COORD_WIDTH-1], ly_reg};
        dz  = {item.tip_z[COORD_WIDTH-1], item.tip_z} - {lz_reg[COORD_WIDTH-1], lz_reg};
        mx  = dx[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dx) : (COORD_WIDTH+1)'(dx);
        my  = dy[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dy) : (COORD_WIDTH+1)'(dy);
        mz  = dz[COORD_WIDTH] ? (COORD_WIDTH+1)'(-dz) : (COORD_WIDTH+1)'(dz);
        sx  = mx * mx;
        sy  = my * my;
        sz  = mz * mz;
        sum = CMP_W'(sx) + CMP_W'(sy) + CMP_W'(sz);
        far = (sum >= CMP_W'(min_sq));
    end

    always_comb
    begin
        logic [NCNT_W-1:0]             n;
        logic signed [COORD_WIDTH-1:0] pa, pb;
        logic                          btn;

        n          = '0;
        set_out    = '0;
        btn        = item.sample_button;
        mode_next  = mode_reg;
        pc_next    = pc_reg;
        tc_next    = tc_reg;
        lx_next    = lx_reg;
        ly_next    = ly_reg;
        lz_next    = lz_reg;
        plane_next = plane_reg;

        if (item.cmd == CMD_PLANE_XY || item.cmd == CMD_PLANE_XZ ||
            item.cmd == CMD_PLANE_YZ)
        begin
            plane_next     = PLANE_WIDTH'(item.cmd - CMD_PLANE_XY);
            set_out.res[n] = mk_res(KIND_PLANE, '0, '0, '0, '0);
            n              = n + NCNT_W'(1);
        end
        if (item.cmd == CMD_RST_CNT)
        begin
            pc_next        = '0;
            tc_next        = '0;
            set_out.res[n] = mk_res(KIND_CNT_RST, '0, '0, '0, '0);
            n              = n + NCNT_W'(1);
        end

        priority case (plane_next)
            PLANE_XY: begin pa = item.tip_x; pb = item.tip_y; end
            PLANE_YZ: begin pa = item.tip_y; pb = item.tip_z; end
            default:  begin pa = item.tip_x; pb = item.tip_z; end
        endcase

        if (!mode_reg)
        begin
            if (btn || item.cmd == CMD_SAMPLE)
            begin
                set_out.res[n] = mk_res(KIND_POINT, pc_next, item.tip_x, item.tip_y,
                                        item.tip_z);
                n              = n + NCNT_W'(1);
                pc_next        = pc_next + COUNT_WIDTH'(1);
            end
            if (item.cmd == CMD_TRACE)
            begin
                mode_next      = 1'b1;
                tc_next        = '0;
                lx_next        = item.tip_x;
                ly_next        = item.tip_y;
                lz_next        = item.tip_z;
                set_out.res[n] = mk_res(KIND_TRACE_START, '0, '0, '0, '0);
                n              = n + NCNT_W'(1);
            end
        end
        else
        begin
            if (far)
            begin
                set_out.res[n] = mk_res(KIND_TRACE_POINT, tc_next, pa, pb, '0);
                n              = n + NCNT_W'(1);
                tc_next        = tc_next + COUNT_WIDTH'(1);
                lx_next        = item.tip_x;
                ly_next        = item.tip_y;
                lz_next        = item.tip_z;
            end
            if (item.cmd == CMD_TRACE || btn)
            begin
                mode_next      = 1'b0;
                set_out.res[n] = mk_res(KIND_TRACE_STOP, '0, '0, '0, '0);
                n              = n + NCNT_W'(1);
            end
        end

        for (int i = 0; i < NRES; i++)
        begin
            set_out.res[i].plane_now = plane_next;
            set_out.res[i].tracing   = mode_next;
            set_out.res[i].last      = (NCNT_W'(i) == n - NCNT_W'(1));
        end
        set_out.n = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            pc_reg    <= '0;
            tc_reg    <= '0;
            lx_reg    <= '0;
            ly_reg    <= '0;
            lz_reg    <= '0;
            plane_reg <= PLANE_XZ;
        end
        else if (commit)
        begin
            mode_reg  <= mode_next;
            pc_reg    <= pc_next;
            tc_reg    <= tc_next;
            lx_reg    <= lx_next;
            ly_reg    <= ly_next;
            lz_reg    <= lz_next;
            plane_reg <= plane_next;
        end
    end
endmodule

// File: rtl/ptdec_obuf.sv
// ptdec_obuf: small result FIFO, loads up to NRES words at once, drains one per cycle while out_ch.ready is high.
// Depends on ptdec_pkg and ptdec_out_if.
module ptdec_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ptdec_pkg::res_set_t set_in,
    output logic                room,
    ptdec_out_if.source         out_ch
);
    import ptdec_pkg::*;

    res_t               fifo_reg [OBUF_DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [PTR_W:0]     cnt_reg, cnt_next;
    logic [PTR_W:0]     add_n;
    logic               fire;
    res_t               head;

    assign room  = (cnt_reg <= (PTR_W+1)'(OBUF_DEPTH - NRES));
    assign fire  = out_ch.valid && out_ch.ready;
    assign add_n = load ? (PTR_W+1)'(set_in.n) : '0;
    assign cnt_next = cnt_reg + add_n - (PTR_W+1)'(fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + PTR_W'(add_n);
            rd_reg  <= rd_reg + PTR_W'(fire);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NRES; i++)
        begin
            if (load && (NCNT_W'(i) < set_in.n))
            begin
                fifo_reg[wr_reg + PTR_W'(i)] <= set_in.res[i];
            end
        end
    end

    assign head              = fifo_reg[rd_reg];
    assign out_ch.valid      = (cnt_reg != '0);
    assign out_ch.kind       = head.kind;
    assign out_ch.index      = head.index;
    assign out_ch.coord_a    = head.coord_a;
    assign out_ch.coord_b    = head.coord_b;
    assign out_ch.coord_c    = head.coord_c;
    assign out_ch.plane_now  = head.plane_now;
    assign out_ch.tracing    = head.tracing;
    assign out_ch.last       = head.last;
endmodule
